>>> sv/id3x_pkg.sv
// Shared types, constants and lookup tables for the ID3v2 tag text extractor.
package id3x_pkg;

    // Number of text slots in the identifier table.
    localparam int NUM_SLOTS = 10;
    // Number of frame body positions searched for an image signature.
    localparam int ART_SCAN  = 128;

    localparam logic [7:0] BIT7 = 8'h80;
    localparam logic [7:0] BIT6 = 8'h40;

    typedef enum logic [2:0] {
        K_ACCEPT   = 3'd0,
        K_ABSENT   = 3'd1,
        K_BAD_VER  = 3'd2,
        K_COMPRESS = 3'd3,
        K_UNIT     = 3'd4,
        K_TEXT_END = 3'd5,
        K_ART      = 3'd6,
        K_TAG_END  = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_HEADER = 3'd1,
        PH_EXT    = 3'd2,
        PH_SKIP   = 3'd3,
        PH_FHEAD  = 3'd4,
        PH_DATA   = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        TM_NONE = 3'd0,
        TM_ENC  = 3'd1,
        TM_CP   = 3'd2,
        TM_BOM0 = 3'd3,
        TM_BOM1 = 3'd4,
        TM_BE   = 3'd5,
        TM_LE   = 3'd6,
        TM_OFF  = 3'd7
    } text_t;

    typedef enum logic [1:0] {
        AF_NONE = 2'd0,
        AF_SEEN = 2'd1,
        AF_DROP = 2'd2
    } unsync_t;

    // One result item.
    typedef struct packed {
        kind_t        kind;
        logic [3:0]   slot;
        logic [15:0]  unit;
        logic [28:0]  pos;
        logic [31:0]  alen;
    } res_t;

    // All results caused by one input byte.
    typedef struct packed {
        logic [1:0]   cnt;
        logic [7:0]   version;
        res_t [2:0]   res;
    } step_t;

    // CP1252 upper half for bytes 0x80 to 0x9f.
    function automatic logic [15:0] cp_hi(input logic [4:0] idx);
        logic [15:0] u;
        case (idx)
            5'd0:  u = 16'h20ac;
            5'd2:  u = 16'h201a;
            5'd3:  u = 16'h0192;
            5'd4:  u = 16'h201e;
            5'd5:  u = 16'h2026;
            5'd6:  u = 16'h2020;
            5'd7:  u = 16'h2021;
            5'd8:  u = 16'h02c6;
            5'd9:  u = 16'h2030;
            5'd10: u = 16'h0160;
            5'd11: u = 16'h2039;
            5'd12: u = 16'h0152;
            5'd14: u = 16'h017d;
            5'd17: u = 16'h2018;
            5'd18: u = 16'h2019;
            5'd19: u = 16'h201c;
            5'd20: u = 16'h201d;
            5'd21: u = 16'h2022;
            5'd22: u = 16'h2013;
            5'd23: u = 16'h2014;
            5'd24: u = 16'h02dc;
            5'd25: u = 16'h2122;
            5'd26: u = 16'h0161;
            5'd27: u = 16'h203a;
            5'd28: u = 16'h0153;
            5'd30: u = 16'h017e;
            5'd31: u = 16'h0178;
            default: u = 16'h0000;
        endcase
        return u;
    endfunction

    // Three-character v2.2 frame identifiers per slot.
    function automatic logic [23:0] id22(input logic [3:0] s);
        logic [23:0] v;
        unique case (s)
            4'd0: v = "TT1";
            4'd1: v = "TT2";
            4'd2: v = "TT3";
            4'd3: v = "TP1";
            4'd4: v = "TAL";
            4'd5: v = "TCM";
            4'd6: v = "TCR";
            4'd7: v = "TOT";
            4'd8: v = "TOL";
            4'd9: v = "TOA";
            default: v = 24'h000000;
        endcase
        return v;
    endfunction

    // Four-character v2.3 frame identifiers per slot.
    function automatic logic [31:0] id23(input logic [3:0] s);
        logic [31:0] v;
        unique case (s)
            4'd0: v = "TIT1";
            4'd1: v = "TIT2";
            4'd2: v = "TIT3";
            4'd3: v = "TPE1";
            4'd4: v = "TALB";
            4'd5: v = "TCOM";
            4'd6: v = "TCOP";
            4'd7: v = "TOAL";
            4'd8: v = "TOLY";
            4'd9: v = "TOPE";
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> sv/id3x_parser.sv
// Front part: takes one tag byte per cycle while take is high and works out all results it causes.
module id3x_parser
    import id3x_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  data_byte,
    input  logic        tag_start,
    output logic        push,
    output step_t       step
);

    phase_t        phase_reg, phase_next;
    logic [7:0]    hdr_reg [9];
    logic [7:0]    hdr_next [9];
    logic [28:0]   raw_count_reg, raw_count_next;
    logic [27:0]   tag_size_reg, tag_size_next;
    logic [28:0]   clean_offset_reg, clean_offset_next;
    logic          unsync_on_reg, unsync_on_next;
    unsync_t       after_reg, after_next;
    logic [7:0]    tag_version_reg, tag_version_next;
    logic [31:0]   skip_left_reg, skip_left_next;
    logic [7:0]    fh_reg [10];
    logic [7:0]    fh_next [10];
    logic [31:0]   frame_left_reg, frame_left_next;
    logic [8:0]    data_idx_reg, data_idx_next;
    logic [3:0]    cur_slot_reg, cur_slot_next;
    text_t         text_mode_reg, text_mode_next;
    logic          units_any_reg, units_any_next;
    logic [8:0]    low_pending_reg, low_pending_next;
    logic [NUM_SLOTS-1:0] filled_reg, filled_next;
    logic [23:0]   art_window_reg, art_window_next;
    logic          art_index_reg, art_index_next;

    always_comb
    begin
        logic [7:0]  b;
        logic [1:0]  nres;
        res_t [2:0]  res;
        logic        ok;
        logic [27:0] size;
        logic [28:0] pos_hdr;
        logic        pass;
        logic [31:0] fsize;
        logic [7:0]  fmt;
        logic [2:0]  extras;
        logic [32:0] sum;
        logic [7:0]  c3;
        logic [3:0]  found;
        logic        have;
        logic [31:0] fl0;
        logic [8:0]  d;
        logic        hit_j;
        logic        hit_p;
        logic [1:0]  k;
        logic        put;
        logic [15:0] u;
        logic [15:0] v;
        logic [3:0]  hlen;

        b = data_byte;
        nres = 2'd0;
        res = '0;
        ok = 1'b0; size = '0; pos_hdr = '0; pass = 1'b1; fsize = '0; fmt = '0;
        extras = '0; sum = '0; c3 = '0; found = '0; have = 1'b0; fl0 = '0; d = '0;
        hit_j = 1'b0; hit_p = 1'b0; k = '0; put = 1'b0; u = '0; v = '0; hlen = '0;

        phase_next        = phase_reg;
        hdr_next          = hdr_reg;
        raw_count_next    = raw_count_reg;
        tag_size_next     = tag_size_reg;
        clean_offset_next = clean_offset_reg;
        unsync_on_next    = unsync_on_reg;
        after_next        = after_reg;
        tag_version_next  = tag_version_reg;
        skip_left_next    = skip_left_reg;
        fh_next           = fh_reg;
        frame_left_next   = frame_left_reg;
        data_idx_next     = data_idx_reg;
        cur_slot_next     = cur_slot_reg;
        text_mode_next    = text_mode_reg;
        units_any_next    = units_any_reg;
        low_pending_next  = low_pending_reg;
        filled_next       = filled_reg;
        art_window_next   = art_window_reg;
        art_index_next    = art_index_reg;

        if (take)
        begin
            // A start mark drops any parse in progress.
            if (tag_start)
            begin
                phase_next        = PH_HEADER;
                raw_count_next    = '0;
                tag_size_next     = '0;
                clean_offset_next = '0;
                unsync_on_next    = 1'b0;
                after_next        = AF_NONE;
                tag_version_next  = '0;
                skip_left_next    = '0;
                frame_left_next   = '0;
                data_idx_next     = '0;
                cur_slot_next     = '0;
                text_mode_next    = TM_NONE;
                units_any_next    = 1'b0;
                low_pending_next  = '0;
                filled_next       = '0;
                art_window_next   = '0;
                art_index_next    = 1'b0;
            end

            if (phase_next == PH_HEADER)
            begin
                // Tag header: collect nine bytes, judge on the tenth.
                if (raw_count_next < 29'd9)
                begin
                    hdr_next[raw_count_next[3:0]] = b;
                    raw_count_next = raw_count_next + 29'd1;
                end
                else
                begin
                    tag_version_next = hdr_next[3];
                    ok = hdr_next[0] == 8'h49 && hdr_next[1] == 8'h44 && hdr_next[2] == 8'h33
                         && hdr_next[3] != 8'hff && hdr_next[4] != 8'hff
                         && !hdr_next[6][7] && !hdr_next[7][7] && !hdr_next[8][7] && !b[7];
                    size = {hdr_next[6][6:0], hdr_next[7][6:0], hdr_next[8][6:0], b[6:0]};
                    pos_hdr = {1'b0, size} + 29'd10;
                    phase_next = PH_IDLE;
                    if (!ok || size == '0)
                    begin
                        res[nres] = '{kind: K_ABSENT, slot: '0, unit: '0, pos: '0, alen: '0};
                        nres = nres + 2'd1;
                    end
                    else if (hdr_next[3] != 8'd2 && hdr_next[3] != 8'd3)
                    begin
                        res[nres] = '{kind: K_BAD_VER, slot: '0, unit: '0, pos: pos_hdr,
                                      alen: '0};
                        nres = nres + 2'd1;
                    end
                    else if (hdr_next[3] == 8'd2 && (hdr_next[5] & BIT6) != 8'h00)
                    begin
                        res[nres] = '{kind: K_COMPRESS, slot: '0, unit: '0, pos: pos_hdr,
                                      alen: '0};
                        nres = nres + 2'd1;
                    end
                    else
                    begin
                        tag_size_next     = size;
                        unsync_on_next    = (hdr_next[5] & BIT7) != 8'h00;
                        raw_count_next    = '0;
                        clean_offset_next = '0;
                        after_next        = AF_NONE;
                        frame_left_next   = '0;
                        res[nres] = '{kind: K_ACCEPT, slot: '0, unit: '0, pos: pos_hdr,
                                      alen: '0};
                        nres = nres + 2'd1;
                        if (hdr_next[3] == 8'd3 && (hdr_next[5] & BIT6) != 8'h00)
                            phase_next = PH_EXT;
                        else
                            phase_next = PH_FHEAD;
                    end
                end
            end
            else if (phase_next != PH_IDLE)
            begin
                // Unsynchronisation: drop a 00 after an ff outside the last two bytes.
                if (after_next == AF_DROP)
                    after_next = AF_NONE;
                else if (after_next == AF_SEEN && b == 8'h00)
                begin
                    pass = 1'b0;
                    after_next = AF_DROP;
                end
                else if (unsync_on_next && b == 8'hff
                         && (raw_count_next + 29'd2) < {1'b0, tag_size_next})
                    after_next = AF_SEEN;
                else
                    after_next = AF_NONE;

                if (pass)
                begin
                    case (phase_next)
                        PH_EXT:
                        begin
                            fh_next[{2'b00, frame_left_next[1:0]}] = b;
                            frame_left_next = frame_left_next + 32'd1;
                            if (frame_left_next == 32'd4)
                            begin
                                skip_left_next = {fh_next[0], fh_next[1], fh_next[2],
                                                  fh_next[3]};
                                frame_left_next = '0;
                                phase_next = (skip_left_next == '0) ? PH_FHEAD : PH_SKIP;
                            end
                        end
                        PH_SKIP:
                        begin
                            skip_left_next = skip_left_next - 32'd1;
                            if (skip_left_next == '0)
                            begin
                                phase_next = PH_FHEAD;
                                frame_left_next = '0;
                            end
                        end
                        PH_FHEAD:
                        begin
                            hlen = (tag_version_next == 8'd2) ? 4'd6 : 4'd10;
                            fh_next[frame_left_next[3:0]] = b;
                            frame_left_next = frame_left_next + 32'd1;
                            if (frame_left_next[3:0] == hlen)
                            begin
                                // Frame header complete: size, flags and identifier.
                                if (tag_version_next == 8'd3)
                                begin
                                    c3 = fh_next[3];
                                    fsize = {fh_next[4], fh_next[5], fh_next[6], fh_next[7]};
                                    fmt = fh_next[9];
                                end
                                else
                                begin
                                    c3 = 8'h00;
                                    fsize = {8'h00, fh_next[3], fh_next[4], fh_next[5]};
                                    fmt = 8'h00;
                                end
                                extras = ((fmt & BIT7) != 8'h00 ? 3'd4 : 3'd0)
                                       + ((fmt & BIT6) != 8'h00 ? 3'd1 : 3'd0);
                                if (extras != 3'd0 || fsize == '0)
                                begin
                                    sum = {1'b0, fsize} + {30'd0, extras};
                                    skip_left_next = sum[32] ? 32'hffffffff : sum[31:0];
                                    frame_left_next = '0;
                                    phase_next = (skip_left_next == '0) ? PH_FHEAD : PH_SKIP;
                                end
                                else
                                begin
                                    frame_left_next  = fsize;
                                    data_idx_next    = '0;
                                    art_window_next  = '0;
                                    art_index_next   = 1'b0;
                                    text_mode_next   = TM_NONE;
                                    units_any_next   = 1'b0;
                                    low_pending_next = '0;
                                    if ({fh_next[0], fh_next[1], fh_next[2]} == "PIC"
                                        || ({fh_next[0], fh_next[1], fh_next[2]} == "API"
                                            && c3 == "C"))
                                        phase_next = PH_DATA;
                                    else
                                    begin
                                        for (int i = NUM_SLOTS - 1; i >= 0; i--)
                                        begin
                                            if ({fh_next[0], fh_next[1], fh_next[2]}
                                                    == id22(4'(i))
                                                || {fh_next[0], fh_next[1], fh_next[2], c3}
                                                    == id23(4'(i)))
                                            begin
                                                found = 4'(i);
                                                have = 1'b1;
                                            end
                                        end
                                        if (!have || filled_next[found])
                                        begin
                                            skip_left_next = fsize;
                                            frame_left_next = '0;
                                            phase_next = PH_SKIP;
                                        end
                                        else
                                        begin
                                            cur_slot_next = found;
                                            text_mode_next = TM_ENC;
                                            phase_next = PH_DATA;
                                        end
                                    end
                                end
                            end
                        end
                        PH_DATA:
                        begin
                            d = data_idx_next;
                            fl0 = frame_left_next;
                            frame_left_next = fl0 - 32'd1;
                            if (data_idx_next != 9'h1ff)
                                data_idx_next = data_idx_next + 9'd1;
                            if (text_mode_next == TM_NONE)
                            begin
                                // Image signature search over a three-byte window.
                                if (!art_index_next)
                                begin
                                    hit_j = d >= 9'd2 && d < 9'(ART_SCAN + 2)
                                            && art_window_next[15:8] == 8'hff
                                            && art_window_next[7:0] == 8'hD8 && b == 8'hff;
                                    hit_p = d >= 9'd3 && d < 9'(ART_SCAN + 3)
                                            && art_window_next[23:16] == 8'h89
                                            && art_window_next[15:8] == 8'h50
                                            && art_window_next[7:0] == 8'h4E && b == 8'h47;
                                    k = hit_p ? 2'd3 : 2'd2;
                                    if (hit_j || hit_p)
                                    begin
                                        res[nres] = '{kind: K_ART, slot: '0, unit: '0,
                                            pos: clean_offset_next + 29'd10 - {27'd0, k},
                                            alen: fl0 + {30'd0, k}};
                                        nres = nres + 2'd1;
                                        art_index_next = 1'b1;
                                    end
                                end
                                art_window_next = {art_window_next[15:0], b};
                            end
                            else
                            begin
                                // Text decoding by encoding state.
                                case (text_mode_next)
                                    TM_ENC:
                                        text_mode_next = (b == 8'd0) ? TM_CP
                                                       : (b == 8'd1) ? TM_BOM0 : TM_OFF;
                                    TM_CP:
                                    begin
                                        put = 1'b1;
                                        u = (b[7:5] == 3'b100) ? cp_hi(b[4:0]) : {8'h00, b};
                                    end
                                    TM_BOM0:
                                    begin
                                        low_pending_next = {1'b0, b};
                                        text_mode_next = TM_BOM1;
                                    end
                                    TM_BOM1:
                                    begin
                                        v = {low_pending_next[7:0], b};
                                        low_pending_next = '0;
                                        if (v == 16'hfeff)
                                            text_mode_next = TM_BE;
                                        else if (v == 16'hfffe)
                                            text_mode_next = TM_LE;
                                        else
                                        begin
                                            text_mode_next = TM_BE;
                                            put = 1'b1;
                                            u = v;
                                        end
                                    end
                                    TM_BE, TM_LE:
                                    begin
                                        if (low_pending_next[8])
                                        begin
                                            u = (text_mode_next == TM_BE)
                                                ? {low_pending_next[7:0], b}
                                                : {b, low_pending_next[7:0]};
                                            low_pending_next = '0;
                                            put = 1'b1;
                                        end
                                        else
                                            low_pending_next = {1'b1, b};
                                    end
                                    default: ;
                                endcase
                                if (put)
                                begin
                                    if (!units_any_next && u == 16'h0000)
                                        text_mode_next = TM_OFF;
                                    else
                                    begin
                                        filled_next[cur_slot_next] = 1'b1;
                                        res[nres] = '{kind: K_UNIT, slot: cur_slot_next,
                                                      unit: u, pos: '0, alen: '0};
                                        nres = nres + 2'd1;
                                        units_any_next = 1'b1;
                                    end
                                end
                            end
                            if (frame_left_next == '0)
                            begin
                                if (text_mode_next != TM_NONE && units_any_next)
                                begin
                                    res[nres] = '{kind: K_TEXT_END, slot: cur_slot_next,
                                                  unit: '0, pos: '0, alen: '0};
                                    nres = nres + 2'd1;
                                end
                                text_mode_next = TM_NONE;
                                phase_next = PH_FHEAD;
                            end
                        end
                        default: ;
                    endcase
                    clean_offset_next = clean_offset_next + 29'd1;
                end

                // End of the raw tag closes any open text.
                raw_count_next = raw_count_next + 29'd1;
                if (raw_count_next == {1'b0, tag_size_next})
                begin
                    if (phase_next == PH_DATA && text_mode_next != TM_NONE && units_any_next)
                    begin
                        res[nres] = '{kind: K_TEXT_END, slot: cur_slot_next, unit: '0,
                                      pos: '0, alen: '0};
                        nres = nres + 2'd1;
                    end
                    res[nres] = '{kind: K_TAG_END, slot: '0, unit: '0,
                                  pos: {1'b0, tag_size_next} + 29'd10, alen: '0};
                    nres = nres + 2'd1;
                    phase_next = PH_IDLE;
                    text_mode_next = TM_NONE;
                end
            end
        end

        push = take && nres != 2'd0;
        step.cnt = nres;
        step.version = tag_version_next;
        step.res = res;
    end

    // Parse state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            raw_count_reg    <= '0;
            tag_size_reg     <= '0;
            clean_offset_reg <= '0;
            unsync_on_reg    <= 1'b0;
            after_reg        <= AF_NONE;
            tag_version_reg  <= '0;
            skip_left_reg    <= '0;
            frame_left_reg   <= '0;
            data_idx_reg     <= '0;
            cur_slot_reg     <= '0;
            text_mode_reg    <= TM_NONE;
            units_any_reg    <= 1'b0;
            low_pending_reg  <= '0;
            filled_reg       <= '0;
            art_window_reg   <= '0;
            art_index_reg    <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            raw_count_reg    <= raw_count_next;
            tag_size_reg     <= tag_size_next;
            clean_offset_reg <= clean_offset_next;
            unsync_on_reg    <= unsync_on_next;
            after_reg        <= after_next;
            tag_version_reg  <= tag_version_next;
            skip_left_reg    <= skip_left_next;
            frame_left_reg   <= frame_left_next;
            data_idx_reg     <= data_idx_next;
            cur_slot_reg     <= cur_slot_next;
            text_mode_reg    <= text_mode_next;
            units_any_reg    <= units_any_next;
            low_pending_reg  <= low_pending_next;
            filled_reg       <= filled_next;
            art_window_reg   <= art_window_next;
            art_index_reg    <= art_index_next;
        end
    end

    // Header and frame header byte stores.
    always_ff @(posedge clk)
    begin
        hdr_reg <= hdr_next;
        fh_reg  <= fh_next;
    end

endmodule

>>> sv/id3x_queue.sv
// Two-entry queue of per-byte result groups between the parser and the output stage.
module id3x_queue
    import id3x_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  step_t wr_data,
    input  logic  pop,
    output step_t head,
    output logic  empty,
    output logic  full
);

    step_t       mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    assign head  = mem_reg[rd_ptr_reg];
    assign empty = count_reg == 2'd0;
    assign full  = count_reg == 2'd2;

endmodule

>>> sv/id3x_emitter.sv
// Back part: hands out the results of the queue head one request at a time.
module id3x_emitter
    import id3x_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  step_t        head,
    input  logic         empty,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   kind,
    output logic [3:0]   slot,
    output logic [15:0]  code_unit,
    output logic [7:0]   version,
    output logic [28:0]  position,
    output logic [31:0]  art_length,
    output logic         last
);

    logic [1:0] idx_reg, idx_next;
    res_t       cur;

    // Select the current result of the group and step through it.
    always_comb
    begin
        cur        = head.res[idx_reg];
        out_valid  = !empty;
        last       = idx_reg == (head.cnt - 2'd1);
        kind       = cur.kind;
        slot       = cur.slot;
        code_unit  = cur.unit;
        version    = head.version;
        position   = cur.pos;
        art_length = cur.alen;
        pop        = out_valid && out_ready && last;
        idx_next   = idx_reg;
        if (out_valid && out_ready)
            idx_next = last ? 2'd0 : idx_reg + 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= '0;
        else
            idx_reg <= idx_next;
    end

endmodule

>>> sv/id3v2_tag_text_extractor_top.sv
// A byte's results are registered in the queue and offered from its head after any earlier groups.
// Throughput: one byte per cycle while the queue is not full; a byte with several results
// hands them out one at a time, and a two-group queue lets the parser run ahead meanwhile.
// Bytes that cause no result take no queue entry.
// Reset (rst_n low, asynchronous) returns the parser to idle and empties the queue.
module id3v2_tag_text_extractor_top
    import id3x_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [7:0]   data_byte,
    input  logic         tag_start,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [2:0]   kind,
    output logic [3:0]   slot,
    output logic [15:0]  code_unit,
    output logic [7:0]   version,
    output logic [28:0]  position,
    output logic [31:0]  art_length,
    output logic         last
);

    logic  push;
    logic  pop;
    logic  empty;
    logic  full;
    step_t step;
    step_t head;

    assign in_ready = !full;

    id3x_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_valid && in_ready),
        .data_byte (data_byte),
        .tag_start (tag_start),
        .push      (push),
        .step      (step)
    );

    id3x_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (step),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    id3x_emitter u_emitter (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .empty      (empty),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .slot       (slot),
        .code_unit  (code_unit),
        .version    (version),
        .position   (position),
        .art_length (art_length),
        .last       (last)
    );

endmodule

>>> sv/id3x_checker.sv
// Port-level checks on the extractor outputs, bound to the top level.
module id3x_checker
    import id3x_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         out_valid,
    input  logic         out_ready,
    input  logic [2:0]   kind,
    input  logic [3:0]   slot,
    input  logic [28:0]  position,
    input  logic         last
);

    // A stalled request stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output request withdrawn while stalled");

    // Text results always name a slot in the table.
    a_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_UNIT || kind == K_TEXT_END) |-> slot < 4'(NUM_SLOTS))
        else $error("text result with slot out of range");

    // Absent and accept header verdicts and tag end close the results of their byte.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == K_ABSENT || kind == K_ACCEPT || kind == K_TAG_END) |-> last)
        else $error("header or tag end result not final");

    // Tag end reports a size of at least one plus the header.
    a_end_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == K_TAG_END |-> position >= 29'd11)
        else $error("tag end position too small");

endmodule

bind id3v2_tag_text_extractor_top id3x_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .kind      (kind),
    .slot      (slot),
    .position  (position),
    .last      (last)
);

>>> sim/tb_id3v2_tag_text_extractor_top.sv
// Self-checking testbench for the ID3v2 tag text extractor top level.
module tb_id3v2_tag_text_extractor_top;
    import id3x_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic [15:0] code_unit;
        logic [7:0]  version;
        logic [28:0] position;
        logic [31:0] art_length;
        logic        last;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        tag_start;
    logic        out_valid;
    logic        out_ready;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic [15:0] code_unit;
    logic [7:0]  version;
    logic [28:0] position;
    logic [31:0] art_length;
    logic        last;

    id3v2_tag_text_extractor_top uut (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .data_byte(data_byte), .tag_start(tag_start), .out_valid(out_valid),
        .out_ready(out_ready), .kind(kind), .slot(slot), .code_unit(code_unit),
        .version(version), .position(position), .art_length(art_length), .last(last)
    );

    // Parser state mirrored from the block's behaviour.
    phase_t     p_phase;
    logic [7:0] p_hdr [9];
    logic [31:0] p_raw, p_tsize, p_clean;
    logic       p_unsync;
    logic [1:0] p_aff;
    logic [7:0] p_ver;
    logic [31:0] p_skip;
    logic [7:0] p_fh [10];
    logic [31:0] p_fleft, p_fsize;
    logic [3:0] p_slot;
    text_t      p_tm;
    logic [30:0] p_units;
    logic [8:0] p_lowp;
    logic [9:0] p_filled;
    logic [23:0] p_win;
    logic       p_found;

    outcome_t expected_results[$];
    outcome_t step_buf[$];

    int  mismatches;
    int  idle_cycles;
    int  ready_gap;
    bit  stall_enable;
    bit  hold_off;
    bit  timed_out;

    // Clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic logic [15:0] cp1252(input logic [7:0] b);
        logic [15:0] t [32];
        t = '{16'h20ac, 0, 16'h201a, 16'h0192, 16'h201e, 16'h2026, 16'h2020, 16'h2021,
              16'h02c6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 0, 16'h017d, 0,
              0, 16'h2018, 16'h2019, 16'h201c, 16'h201d, 16'h2022, 16'h2013, 16'h2014,
              16'h02dc, 16'h2122, 16'h0161, 16'h203a, 16'h0153, 0, 16'h017e, 16'h0178};
        if (b >= 8'h80 && b < 8'ha0)
            return t[b - 8'h80];
        return {8'h00, b};
    endfunction

    task automatic push_result(input kind_t k, input logic [3:0] s, input logic [15:0] u,
                               input logic [31:0] pos, input logic [31:0] alen);
        outcome_t o;
        if (step_buf.size() >= 3)
            return;
        o.kind = k;
        o.slot = s;
        o.code_unit = u;
        o.version = p_ver;
        o.position = pos[28:0];
        o.art_length = alen;
        o.last = 1'b0;
        step_buf.push_back(o);
    endtask

    task automatic clear_parser();
        p_phase = PH_IDLE;
        foreach (p_hdr[i]) p_hdr[i] = 0;
        foreach (p_fh[i]) p_fh[i] = 0;
        p_raw = 0; p_tsize = 0; p_clean = 0; p_unsync = 0; p_aff = 0; p_ver = 0;
        p_skip = 0; p_fleft = 0; p_fsize = 0; p_slot = 0; p_tm = TM_NONE;
        p_units = 0; p_lowp = 0; p_filled = 0; p_win = 0; p_found = 0;
    endtask

    task automatic enter_skip();
        p_fleft = 0;
        p_phase = (p_skip == 0) ? PH_FHEAD : PH_SKIP;
    endtask

    task automatic emit_unit(input logic [15:0] u);
        if (p_units == 0)
        begin
            if (u == 0)
            begin
                p_tm = TM_OFF;
                return;
            end
            p_filled[p_slot] = 1'b1;
        end
        push_result(K_UNIT, p_slot, u, 0, 0);
        if (p_units != 31'h7fffffff)
            p_units++;
    endtask

    task automatic decode_text(input logic [7:0] b);
        logic [15:0] v;
        case (p_tm)
            TM_ENC:  p_tm = (b == 0) ? TM_CP : (b == 1) ? TM_BOM0 : TM_OFF;
            TM_CP:   emit_unit(cp1252(b));
            TM_BOM0:
            begin
                p_lowp = {1'b0, b};
                p_tm = TM_BOM1;
            end
            TM_BOM1:
            begin
                v = {p_lowp[7:0], b};
                p_lowp = 0;
                if (v == 16'hfeff)
                    p_tm = TM_BE;
                else if (v == 16'hfffe)
                    p_tm = TM_LE;
                else
                begin
                    p_tm = TM_BE;
                    emit_unit(v);
                end
            end
            TM_BE, TM_LE:
            begin
                if (p_lowp[8])
                begin
                    v = (p_tm == TM_BE) ? {p_lowp[7:0], b} : {b, p_lowp[7:0]};
                    p_lowp = 0;
                    emit_unit(v);
                end
                else
                    p_lowp = {1'b1, b};
            end
            default: ;
        endcase
    endtask

    task automatic scan_art(input logic [7:0] b, input logic [31:0] d);
        logic [31:0] k;
        bit hit;
        hit = 0;
        k = 0;
        if (!p_found)
        begin
            if (d >= 2 && d - 2 < ART_SCAN && p_win[15:8] == 8'hff && p_win[7:0] == 8'hd8
                && b == 8'hff)
            begin
                hit = 1;
                k = 2;
            end
            if (d >= 3 && d - 3 < ART_SCAN && p_win[23:16] == 8'h89 && p_win[15:8] == 8'h50
                && p_win[7:0] == 8'h4e && b == 8'h47)
            begin
                hit = 1;
                k = 3;
            end
            if (hit)
            begin
                push_result(K_ART, 0, 0, 32'd10 + p_clean - k, p_fsize - (d - k));
                p_found = 1;
            end
        end
        p_win = {p_win[15:0], b};
    endtask

    task automatic open_frame();
        bit v3;
        logic [7:0] c3;
        logic [31:0] size;
        logic [7:0] fmt;
        logic [32:0] sum;
        int hit;
        v3 = (p_ver == 3);
        c3 = v3 ? p_fh[3] : 8'h00;
        hit = NUM_SLOTS;
        if (v3)
        begin
            size = {p_fh[4], p_fh[5], p_fh[6], p_fh[7]};
            fmt = p_fh[9];
        end
        else
        begin
            size = {8'h00, p_fh[3], p_fh[4], p_fh[5]};
            fmt = 0;
        end
        sum = size + ((fmt & BIT7) != 0 ? 4 : 0) + ((fmt & BIT6) != 0 ? 1 : 0);
        if (sum != {1'b0, size} || size == 0)
        begin
            p_skip = sum[32] ? 32'hffffffff : sum[31:0];
            enter_skip();
            return;
        end
        p_fsize = size;
        p_fleft = size;
        p_win = 0; p_found = 0; p_tm = TM_NONE; p_units = 0; p_lowp = 0;
        if ({p_fh[0], p_fh[1], p_fh[2]} == "PIC" || ({p_fh[0], p_fh[1], p_fh[2]} == "API"
            && c3 == "C"))
        begin
            p_phase = PH_DATA;
            return;
        end
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            if (hit == NUM_SLOTS && ({p_fh[0], p_fh[1], p_fh[2]} == id22(i) ||
                {p_fh[0], p_fh[1], p_fh[2], c3} == id23(i)))
                hit = i;
        end
        if (hit == NUM_SLOTS || p_filled[hit])
        begin
            p_skip = size;
            enter_skip();
            return;
        end
        p_slot = hit;
        p_tm = TM_ENC;
        p_phase = PH_DATA;
    endtask

    task automatic parse_clean(input logic [7:0] b);
        logic [31:0] d;
        case (p_phase)
            PH_EXT:
            begin
                p_fh[p_fleft[1:0]] = b;
                p_fleft++;
                if (p_fleft >= 4)
                begin
                    p_skip = {p_fh[0], p_fh[1], p_fh[2], p_fh[3]};
                    enter_skip();
                end
            end
            PH_SKIP:
            begin
                p_skip--;
                if (p_skip == 0)
                begin
                    p_phase = PH_FHEAD;
                    p_fleft = 0;
                end
            end
            PH_FHEAD:
            begin
                if (p_fleft < 10)
                    p_fh[p_fleft] = b;
                p_fleft++;
                if (p_fleft >= ((p_ver == 2) ? 6 : 10))
                    open_frame();
            end
            PH_DATA:
            begin
                d = p_fsize - p_fleft;
                p_fleft--;
                if (p_tm == TM_NONE)
                    scan_art(b, d);
                else
                    decode_text(b);
                if (p_fleft == 0)
                begin
                    if (p_tm != TM_NONE && p_units > 0)
                        push_result(K_TEXT_END, p_slot, 0, 0, 0);
                    p_tm = TM_NONE;
                    p_phase = PH_FHEAD;
                end
            end
            default: ;
        endcase
    endtask

    task automatic parse_header(input logic [7:0] b);
        logic [31:0] size;
        bit ok;
        if (p_raw < 9)
        begin
            p_hdr[p_raw] = b;
            p_raw++;
            return;
        end
        p_ver = p_hdr[3];
        ok = p_hdr[0] == 8'h49 && p_hdr[1] == 8'h44 && p_hdr[2] == 8'h33 && p_hdr[3] != 8'hff
             && p_hdr[4] != 8'hff && p_hdr[6] < 8'h80 && p_hdr[7] < 8'h80 && p_hdr[8] < 8'h80
             && b < 8'h80;
        size = (32'(p_hdr[6]) << 21) | (32'(p_hdr[7]) << 14) | (32'(p_hdr[8]) << 7) | b;
        p_phase = PH_IDLE;
        if (!ok || size == 0)
            push_result(K_ABSENT, 0, 0, 0, 0);
        else if (p_ver != 2 && p_ver != 3)
            push_result(K_BAD_VER, 0, 0, size + 10, 0);
        else if (p_ver == 2 && (p_hdr[5] & BIT6) != 0)
            push_result(K_COMPRESS, 0, 0, size + 10, 0);
        else
        begin
            p_tsize = size;
            p_unsync = (p_hdr[5] & BIT7) != 0;
            p_raw = 0; p_clean = 0; p_aff = 0; p_fleft = 0;
            push_result(K_ACCEPT, 0, 0, size + 10, 0);
            p_phase = (p_ver == 3 && (p_hdr[5] & BIT6) != 0) ? PH_EXT : PH_FHEAD;
        end
    endtask

    task automatic parse_body(input logic [7:0] b);
        bit pass;
        pass = 1;
        if (p_aff == 2)
            p_aff = 0;
        else if (p_aff == 1 && b == 0)
        begin
            pass = 0;
            p_aff = 2;
        end
        else
            p_aff = (p_unsync && b == 8'hff && p_raw + 2 < p_tsize) ? 2'd1 : 2'd0;
        if (pass)
        begin
            parse_clean(b);
            p_clean++;
        end
        p_raw++;
        if (p_raw >= p_tsize)
        begin
            if (p_phase == PH_DATA && p_tm != TM_NONE && p_units > 0)
                push_result(K_TEXT_END, p_slot, 0, 0, 0);
            push_result(K_TAG_END, 0, 0, p_tsize + 10, 0);
            p_phase = PH_IDLE;
            p_tm = TM_NONE;
        end
    endtask

    // Predict the results of one accepted request and queue them.
    task automatic predict_byte(input logic [7:0] b, input logic ts);
        step_buf.delete();
        if (ts)
        begin
            clear_parser();
            p_phase = PH_HEADER;
        end
        if (p_phase == PH_HEADER)
            parse_header(b);
        else if (p_phase != PH_IDLE)
            parse_body(b);
        if (step_buf.size() > 0)
            step_buf[step_buf.size() - 1].last = 1'b1;
        foreach (step_buf[i]) expected_results.push_back(step_buf[i]);
    endtask

    // Offer one request, with an optional random gap first.
    task automatic send_byte(input logic [7:0] b, input logic ts);
        if (stall_enable && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        tag_start <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_byte(b, ts);
        @(negedge clk);
    endtask

    task automatic send_header(input logic [7:0] ver, input logic [7:0] flags,
                               input logic [27:0] size);
        send_byte(8'h49, 1'b1);
        send_byte(8'h44, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(ver, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(flags, 1'b0);
        send_byte({1'b0, size[27:21]}, 1'b0);
        send_byte({1'b0, size[20:14]}, 1'b0);
        send_byte({1'b0, size[13:7]}, 1'b0);
        send_byte({1'b0, size[6:0]}, 1'b0);
    endtask

    task automatic send_list(input logic [7:0] bytes[$]);
        foreach (bytes[i]) send_byte(bytes[i], 1'b0);
    endtask

    // Build and send a whole tag; body is sent as given.
    task automatic send_tag(input logic [7:0] ver, input logic [7:0] flags,
                            input logic [7:0] body[$]);
        send_header(ver, flags, body.size());
        send_list(body);
    endtask

    function automatic void add_frame(ref logic [7:0] body[$], input logic [31:0] id,
                                      input logic [7:0] ver, input logic [7:0] fmt,
                                      input logic [7:0] data[$]);
        if (ver == 2)
        begin
            body.push_back(id[31:24]); body.push_back(id[23:16]); body.push_back(id[15:8]);
            body.push_back(8'(data.size() >> 16));
            body.push_back(8'(data.size() >> 8));
            body.push_back(8'(data.size()));
        end
        else
        begin
            body.push_back(id[31:24]); body.push_back(id[23:16]);
            body.push_back(id[15:8]); body.push_back(id[7:0]);
            body.push_back(8'(data.size() >> 24)); body.push_back(8'(data.size() >> 16));
            body.push_back(8'(data.size() >> 8)); body.push_back(8'(data.size()));
            body.push_back(8'h00); body.push_back(fmt);
        end
        foreach (data[i]) body.push_back(data[i]);
    endfunction

    function automatic logic [31:0] random_id(input logic [7:0] ver);
        int s;
        s = $urandom_range(0, 13);
        if (s < NUM_SLOTS)
            return (ver == 2) ? {id22(s), 8'h00} : id23(s);
        if (s == 10)
            return (ver == 2) ? "PIC\0" : "APIC";
        return {8'($urandom_range(65, 90)), 8'($urandom), 8'($urandom), 8'($urandom)};
    endfunction

    function automatic void random_payload(ref logic [7:0] data[$]);
        int n;
        int mode;
        n = $urandom_range(1, 12);
        mode = $urandom_range(0, 5);
        data.delete();
        case (mode)
            0: data.push_back(8'h00);
            1: begin data.push_back(8'h01); data.push_back(8'hfe); data.push_back(8'hff); end
            2: begin data.push_back(8'h01); data.push_back(8'hff); data.push_back(8'hfe); end
            3: data.push_back(8'h01);
            4: begin data.push_back(8'hff); data.push_back(8'hd8); data.push_back(8'hff); end
            default: begin data.push_back(8'h89); data.push_back(8'h50);
                           data.push_back(8'h4e); data.push_back(8'h47); end
        endcase
        repeat (n) data.push_back(8'($urandom));
    endfunction

    // Stop offering and wait until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
    endtask

    // Checker: compare each accepted result with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            outcome_t got;
            outcome_t want;
            got = {kind, slot, code_unit, version, position, art_length, last};
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result %h", got);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected %h, got %h", want, got);
                end
            end
        end
    end

    // Receiver: random back-pressure in bursts, and a long hold-off when requested.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            ready_gap = 0;
            out_ready <= 1'b0;
        end
        else if (hold_off)
            out_ready <= 1'b0;
        else if (ready_gap > 0)
        begin
            ready_gap--;
            out_ready <= 1'b0;
        end
        else if (stall_enable && out_ready && $urandom_range(0, 4) == 0)
        begin
            ready_gap = $urandom_range(0, 4);
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Watchdog: count cycles with no accepted request on either side.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out)
        begin
            timed_out = 1;
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_headers();
        send_byte(8'h12, 1'b0);
        send_header(8'h04, 8'h00, 28'd5);
        send_header(8'h02, 8'h40, 28'd5);
        send_header(8'h03, 8'h00, 28'd0);
        send_byte(8'h49, 1'b1); send_byte(8'h44, 1'b0); send_byte(8'h33, 1'b0);
        send_byte(8'h03, 1'b0); send_byte(8'hff, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0); send_byte(8'h00, 1'b0); send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h00, 1'b0);
        drain();
    endtask

    task automatic test_text_frames();
        logic [7:0] body[$];
        logic [7:0] d[$];
        body.delete();
        d = '{8'h00, 8'h41, 8'h80, 8'h81, 8'h9f, 8'hff};
        add_frame(body, id23(1), 3, 0, d);
        d = '{8'h01, 8'hff, 8'hfe, 8'h34, 8'h12, 8'h7f};
        add_frame(body, id23(3), 3, 0, d);
        d = '{8'h01, 8'h00, 8'h41};
        add_frame(body, id23(1), 3, 0, d);
        d = '{8'h00, 8'h00, 8'h41};
        add_frame(body, id23(4), 3, 0, d);
        d = '{8'h00, 8'h41};
        add_frame(body, id23(0), 3, 8'h80, d);
        send_tag(8'h03, 8'h00, body);
        drain();
        // v2.2 tag with unsynchronisation, an extended-header-free truncated text.
        body.delete();
        d = '{8'h00, 8'hff, 8'h00, 8'h42};
        add_frame(body, {id22(8), 8'h00}, 2, 0, d);
        d = '{8'h00, 8'h43, 8'h44, 8'h45};
        add_frame(body, {id22(5), 8'h00}, 2, 0, d);
        void'(body.pop_back());
        body.push_back(8'hff);
        body.push_back(8'h00);
        send_tag(8'h02, 8'h80, body);
        drain();
    endtask

    task automatic test_artwork();
        logic [7:0] body[$];
        logic [7:0] d[$];
        // Empty extended header, then an image frame with two signatures.
        body.delete();
        repeat (4) body.push_back(8'h00);
        d = '{8'h01, 8'h89, 8'h50, 8'h4e, 8'h47, 8'hff, 8'hd8, 8'hff};
        add_frame(body, "APIC", 3, 0, d);
        send_tag(8'h03, 8'h40, body);
        drain();
    endtask

    // Random tags, mostly well formed.
    task automatic test_random_tags(input int n_bytes, input bit idling);
        logic [7:0] body[$];
        logic [7:0] d[$];
        logic [7:0] ver;
        int sent;
        sent = 0;
        stall_enable = idling;
        while (sent < n_bytes && !timed_out)
        begin
            ver = ($urandom_range(0, 1) == 0) ? 8'h02 : 8'h03;
            body.delete();
            repeat ($urandom_range(1, 3))
            begin
                random_payload(d);
                add_frame(body, random_id(ver), ver,
                          ($urandom_range(0, 5) == 0) ? 8'($urandom) : 8'h00, d);
            end
            if ($urandom_range(0, 3) == 0)
                repeat ($urandom_range(1, 4)) body.push_back(8'($urandom));
            if ($urandom_range(0, 3) == 0)
                body.insert($urandom_range(0, body.size() - 1), 8'hff);
            if ($urandom_range(0, 4) == 0)
                send_byte(8'($urandom), 1'b1);
            send_tag(ver, ($urandom_range(0, 2) == 0) ? 8'h80 : 8'h00, body);
            sent += body.size() + 10;
        end
        drain();
    endtask

    // Long receiver hold-off while a text tag keeps the queue filling.
    task automatic test_backpressure();
        logic [7:0] body[$];
        logic [7:0] d[$];
        stall_enable = 1'b0;
        body.delete();
        d = '{8'h00, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46};
        add_frame(body, id23(1), 3, 0, d);
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(posedge clk);
                hold_off = 1'b0;
            end
            send_tag(8'h03, 8'h00, body);
        join
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        tag_start = 1'b0;
        out_ready = 1'b0;
        hold_off = 1'b0;
        stall_enable = 1'b1;
        mismatches = 0;
        idle_cycles = 0;
        timed_out = 0;
        clear_parser();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_headers();
        test_text_frames();
        test_artwork();
        test_random_tags(20, 1'b1);
        test_backpressure();
        drain();
        repeat (10) @(posedge clk);

        if (mismatches == 0 && expected_results.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
